// File: hw/rtl/ldf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared constants for the length-prefix deframer: parse phase codes,
// header and stream widths, and the packing of the result beat.
// ----------------------------------------------------------------------------
package ldf_pkg;

    // Stream byte and header widths
    localparam int BYTE_W          = 8;
    localparam int HDR_W           = 16;

    // Default width of the length value
    localparam int LENGTH_BITS_DEF = 16;

    // Parse phase codes
    localparam logic [1:0] PH_HDR_LO  = 2'd0;
    localparam logic [1:0] PH_HDR_HI  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // Result beat packing: tdata = {packet_length, payload_byte}
    localparam int OUT_TDATA_W     = 24;
    localparam int OUT_TUSER_W     = 2;
    localparam int TUSER_FIRST     = 0;
    localparam int TUSER_EMPTY     = 1;

endpackage

// File: hw/rtl/length_prefix_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefix_deframer_unit
// Splits a byte stream into packets framed by a 16-bit little-endian length
// header and delivers each payload byte with first/last/empty marks.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock while the output is not stalled and
// gives at most one result beat per byte, in the cycle after the byte is accepted.
// Header bytes give no beat; a zero-length packet gives a single beat marked
// empty and last. The parse state is updated by a small combinational phase
// update, and one output register holds the result, so a byte is accepted in
// every cycle in which the output register is empty or being drained
// (s_axis_tready follows m_axis_tready while a beat is held).
// LENGTH_BITS below 16 masks the header to that many bits.
// ----------------------------------------------------------------------------
module length_prefix_deframer_unit #(
    parameter int LENGTH_BITS = ldf_pkg::LENGTH_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Byte stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [ldf_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
    // Result beats out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [ldf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] payload_byte,
                                                            // [23:8] packet_length
    output logic [ldf_pkg::OUT_TUSER_W-1:0] m_axis_tuser,   // [0] is_first,
                                                            // [1] is_empty
    output logic                            m_axis_tlast    // is_last
);

    // Counter width: header is never wider than 16 bits
    localparam int CntW = (LENGTH_BITS < ldf_pkg::HDR_W) ? LENGTH_BITS : ldf_pkg::HDR_W;
    localparam logic [CntW-1:0] CntOne = CntW'(1);

    // Parse state
    logic [1:0]                  r_phase,        n_phase;
    logic [ldf_pkg::BYTE_W-1:0]  r_header_low,   n_header_low;
    logic [CntW-1:0]             r_frame_length, n_frame_length;
    logic [CntW-1:0]             r_bytes_left,   n_bytes_left;

    // Output register
    logic                        r_m_valid;
    logic [ldf_pkg::BYTE_W-1:0]  r_payload_byte;
    logic [ldf_pkg::HDR_W-1:0]   r_packet_length;
    logic                        r_is_first;
    logic                        r_is_last;
    logic                        r_is_empty;

    // Per-byte result
    logic                        s_take;
    logic                        emit;
    logic [ldf_pkg::BYTE_W-1:0]  res_byte;
    logic [CntW-1:0]             res_length;
    logic                        res_first;
    logic                        res_last;
    logic                        res_empty;
    logic [ldf_pkg::HDR_W-1:0]   hdr_word;
    logic [CntW-1:0]             hdr_len;
    logic [CntW-1:0]             left_dec;

    // Handshake: accept while the output register is free or draining
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    assign hdr_word = {s_axis_tdata, r_header_low};
    assign hdr_len  = hdr_word[CntW-1:0];
    assign left_dec = r_bytes_left - CntOne;

    // Phase update and result selection
    always_comb begin
        n_phase        = r_phase;
        n_header_low   = r_header_low;
        n_frame_length = r_frame_length;
        n_bytes_left   = r_bytes_left;
        emit           = 1'b0;
        res_byte       = '0;
        res_length     = '0;
        res_first      = 1'b0;
        res_last       = 1'b0;
        res_empty      = 1'b0;
        if (r_phase == ldf_pkg::PH_HDR_HI) begin
            n_header_low = '0;
            if (hdr_len == '0) begin
                // zero-length packet: one empty beat
                n_frame_length = '0;
                n_bytes_left   = '0;
                n_phase        = ldf_pkg::PH_HDR_LO;
                emit           = 1'b1;
                res_last       = 1'b1;
                res_empty      = 1'b1;
            end else begin
                n_frame_length = hdr_len;
                n_bytes_left   = hdr_len;
                n_phase        = ldf_pkg::PH_PAYLOAD;
            end
        end else if (r_phase == ldf_pkg::PH_PAYLOAD && r_bytes_left != '0) begin
            emit         = 1'b1;
            res_byte     = s_axis_tdata;
            res_length   = r_frame_length;
            res_first    = (r_bytes_left == r_frame_length);
            res_last     = (r_bytes_left == CntOne);
            n_bytes_left = left_dec;
            if (left_dec == '0) begin
                n_frame_length = '0;
                n_phase        = ldf_pkg::PH_HDR_LO;
            end
        end else begin
            // header low byte; unused code and drained payload land here too
            n_header_low   = s_axis_tdata;
            n_bytes_left   = '0;
            n_frame_length = '0;
            n_phase        = ldf_pkg::PH_HDR_HI;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= ldf_pkg::PH_HDR_LO;
            r_header_low   <= '0;
            r_frame_length <= '0;
            r_bytes_left   <= '0;
        end else if (s_take) begin
            r_phase        <= n_phase;
            r_header_low   <= n_header_low;
            r_frame_length <= n_frame_length;
            r_bytes_left   <= n_bytes_left;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_take && emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (s_take && emit) begin
            r_payload_byte  <= res_byte;
            r_packet_length <= ldf_pkg::HDR_W'(res_length);
            r_is_first      <= res_first;
            r_is_last       <= res_last;
            r_is_empty      <= res_empty;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_packet_length, r_payload_byte};
    assign m_axis_tuser  = {r_is_empty, r_is_first};
    assign m_axis_tlast  = r_is_last;

endmodule

// File: hw/rtl/ldf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldf_checker
// Port-level checks on the length-prefix deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ldf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [ldf_pkg::BYTE_W-1:0]      s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ldf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [ldf_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                            m_axis_tlast
);

    logic beat_first;
    logic beat_empty;
    logic [ldf_pkg::HDR_W-1:0] beat_len;

    assign beat_first = m_axis_tuser[ldf_pkg::TUSER_FIRST];
    assign beat_empty = m_axis_tuser[ldf_pkg::TUSER_EMPTY];
    assign beat_len   = m_axis_tdata[ldf_pkg::OUT_TDATA_W-1:ldf_pkg::BYTE_W];

    // Stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    // Empty output register never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // Empty-packet beat is last, not first, zero length and zero byte
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && beat_empty |-> m_axis_tlast && !beat_first
            && m_axis_tdata == '0)
        else $error("malformed empty-packet beat");

    // A payload beat carries a nonzero length; first and last together mean one byte
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !beat_empty |-> beat_len != '0
            && (!(beat_first && m_axis_tlast) || beat_len == ldf_pkg::HDR_W'(1)))
        else $error("payload beat length inconsistent with marks");

endmodule

bind length_prefix_deframer_unit ldf_checker u_ldf_checker (.*);
